// ===== rtl/irn_pkg.sv =====
// shared types, codes and defaults for the image rotate unit
package irn_pkg;

	localparam int DEF_MAX_WIDTH      = 256;
	localparam int DEF_MAX_HEIGHT     = 256;
	localparam int DEF_TRIG_FRAC_BITS = 14;

	localparam int CFG_DIM_W   = 9;
	localparam int CFG_TRIG_W  = 16;
	localparam int CFG_CTR_W   = 10;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 16;
	localparam int PIX_COORD_W = 9;
	localparam int COLOR_W     = 8;
	localparam int PIX_W       = 3 * COLOR_W;
	localparam int CMD_W       = 2;

	localparam logic [PIX_W-1:0] PIX_WHITE = {PIX_W{1'b1}};

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COS          = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SIN          = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CENTER_X     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y     = 3'd5;

	typedef enum logic [CMD_W-1:0] {
		CMD_WRITE  = 2'd0,
		CMD_READ   = 2'd1,
		CMD_ROTATE = 2'd2
	} cmd_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_RD,
		S_CPY_RD,
		S_CPY_WR,
		S_MAP_RD,
		S_MAP_WAIT,
		S_MAP_WR,
		S_FIN
	} state_t;

endpackage

// ===== rtl/irn_if.sv =====
// handshake channels of the image rotate unit
interface irn_req_if import irn_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic [CMD_W-1:0]       command;
	logic [PIX_COORD_W-1:0] pixel_x;
	logic [PIX_COORD_W-1:0] pixel_y;
	logic [COLOR_W-1:0]     red_in;
	logic [COLOR_W-1:0]     green_in;
	logic [COLOR_W-1:0]     blue_in;
	modport source (output valid, command, pixel_x, pixel_y, red_in, green_in, blue_in,
		input ready);
	modport sink (input valid, command, pixel_x, pixel_y, red_in, green_in, blue_in,
		output ready);
endinterface

interface irn_rsp_if import irn_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               status;
	logic [COLOR_W-1:0] red_out;
	logic [COLOR_W-1:0] green_out;
	logic [COLOR_W-1:0] blue_out;
	modport source (output valid, status, red_out, green_out, blue_out, input ready);
	modport sink (input valid, status, red_out, green_out, blue_out, output ready);
endinterface

interface irn_cfg_if import irn_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/irn_mem.sv =====
// single write port, single registered read port pixel memory
module irn_mem #(
	parameter int ADDR_W = 16,
	parameter int DATA_W = 24
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);
	localparam int DEPTH = 1 << ADDR_W;

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [DATA_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

// ===== rtl/irn_mac.sv =====
// shared multiplier that maps one source offset through the rotation matrix
module irn_mac import irn_pkg::*; #(
	parameter int XW = 12,
	parameter int TRIG_FRAC_BITS = DEF_TRIG_FRAC_BITS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic signed [XW-1:0]                x,
	input  logic signed [XW-1:0]                y,
	input  logic signed [CFG_TRIG_W-1:0]        cos_v,
	input  logic signed [CFG_TRIG_W-1:0]        sin_v,
	output logic                                done,
	output logic signed [XW+CFG_TRIG_W:0]       dx,
	output logic signed [XW+CFG_TRIG_W:0]       dy
);
	localparam int PW = XW + CFG_TRIG_W;
	localparam int AW = PW + 1;
	localparam logic [AW-1:0] HALF = {{(AW-1){1'b0}}, 1'b1} << (TRIG_FRAC_BITS - 1);

	localparam logic [2:0] STEP_XC  = 3'd0;
	localparam logic [2:0] STEP_YS  = 3'd1;
	localparam logic [2:0] STEP_YC  = 3'd2;
	localparam logic [2:0] STEP_XS  = 3'd3;
	localparam logic [2:0] STEP_ACC = 3'd4;
	localparam logic [2:0] STEP_RND = 3'd5;

	logic                 busy_q;
	logic                 done_q;
	logic [2:0]           step_q;
	logic signed [XW-1:0] x_q;
	logic signed [XW-1:0] y_q;
	logic signed [PW-1:0] p_q;
	logic signed [AW-1:0] accx_q;
	logic signed [AW-1:0] accy_q;
	logic signed [AW-1:0] dx_q;
	logic signed [AW-1:0] dy_q;

	logic signed [XW-1:0]         mul_a;
	logic signed [CFG_TRIG_W-1:0] mul_b;
	logic signed [PW-1:0]         prod;
	logic signed [AW-1:0]         p_ext;

	// divide by 2^F, half away from zero
	function automatic logic signed [AW-1:0] rnd(input logic signed [AW-1:0] v);
		logic [AW-1:0] mag;
		logic [AW-1:0] q;
		mag = v[AW-1] ? AW'(-v) : AW'(v);
		q   = (mag + HALF) >> TRIG_FRAC_BITS;
		rnd = v[AW-1] ? signed'(AW'(-q)) : signed'(q);
	endfunction

	always_comb begin
		mul_a = (step_q == STEP_XC || step_q == STEP_XS) ? x_q : y_q;
		mul_b = (step_q == STEP_XC || step_q == STEP_YC) ? cos_v : sin_v;
		prod  = PW'(mul_a * mul_b);
		p_ext = {p_q[PW-1], p_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= STEP_XC;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			step_q <= STEP_XC;
		end else if (busy_q) begin
			step_q <= step_q + 3'd1;
			if (step_q == STEP_RND) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= x;
			y_q <= y;
		end else if (busy_q) begin
			p_q <= prod;
			case (step_q)
				STEP_YS:  accx_q <= p_ext;
				STEP_YC:  accx_q <= accx_q + p_ext;
				STEP_XS:  accy_q <= p_ext;
				STEP_ACC: accy_q <= accy_q - p_ext;
				STEP_RND: begin
					dx_q <= rnd(accx_q);
					dy_q <= rnd(accy_q);
				end
				default: ;
			endcase
		end
	end

	assign done = done_q;
	assign dx   = dx_q;
	assign dy   = dy_q;
endmodule

// ===== rtl/image_rotate_nearest_forward_unit.sv =====
// a pixel write goes through S_FIN, a read through S_RD and S_FIN; S_FIN holds
// until the output slot is free. rotate copies and whitens each pixel (S_CPY_RD,
// S_CPY_WR), then maps each pixel (S_MAP_RD, S_MAP_WAIT, S_MAP_WR) on the shared
// multiplier (four products a pixel). one item at a time; a new item is taken once
// the previous one has finished. reset clears control state and loads the register
// defaults; pixel memories are not cleared
module image_rotate_nearest_forward_unit import irn_pkg::*; #(
	parameter int MAX_WIDTH      = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT     = DEF_MAX_HEIGHT,
	parameter int TRIG_FRAC_BITS = DEF_TRIG_FRAC_BITS
) (
	input  logic   clk,
	input  logic   arst_n,
	irn_req_if.sink   req,
	irn_rsp_if.source rsp,
	irn_cfg_if.sink   cfg
);
	localparam int WB   = $clog2(MAX_WIDTH + 1);
	localparam int HB   = $clog2(MAX_HEIGHT + 1);
	localparam int DW_W = (WB > CFG_DIM_W) ? WB : CFG_DIM_W;
	localparam int DH_W = (HB > CFG_DIM_W) ? HB : CFG_DIM_W;
	localparam int XW   = ((DW_W > DH_W) ? DW_W : DH_W) + 2;
	localparam int RW   = XW + CFG_TRIG_W + 1;
	localparam int DXW  = RW + 1;
	localparam int XAW  = $clog2(MAX_WIDTH);
	localparam int YAW  = $clog2(MAX_HEIGHT);
	localparam int MAW  = XAW + YAW;

	state_t state_q, state_d;

	logic [CFG_DIM_W-1:0]         width_q, height_q;
	logic signed [CFG_TRIG_W-1:0] cos_q, sin_q;
	logic signed [CFG_CTR_W-1:0]  cx_q, cy_q;

	logic [DW_W-1:0] i_q;
	logic [DH_W-1:0] j_q;
	logic            status_q;
	logic            inside_q;
	logic [PIX_W-1:0] pix_q;

	logic               rsp_valid_q;
	logic               rsp_status_q;
	logic [PIX_W-1:0]   rsp_pix_q;

	logic [DW_W-1:0] eff_w;
	logic [DH_W-1:0] eff_h;
	logic            req_acc;
	logic            req_inside;
	cmd_t            req_cmd;
	logic [MAW-1:0]  req_addr, loop_addr, dst_addr;
	logic            last_i, last_j;
	logic            slot_free;

	logic signed [XW-1:0] src_x, src_y;
	logic                 mac_start, mac_done;
	logic signed [RW-1:0] mac_dx, mac_dy;
	logic signed [DXW-1:0] dst_x, dst_y;
	logic                 dst_hit;

	logic             fr_we, fr_re, sc_we, sc_re;
	logic [MAW-1:0]   fr_waddr, fr_raddr;
	logic [PIX_W-1:0] fr_wdata, fr_rdata, sc_rdata;

	// configuration
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= CFG_DIM_W'(256);
			height_q <= CFG_DIM_W'(256);
			cos_q    <= CFG_TRIG_W'(16384);
			sin_q    <= '0;
			cx_q     <= '0;
			cy_q     <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_FRAME_WIDTH:  width_q  <= cfg.data[CFG_DIM_W-1:0];
				REG_FRAME_HEIGHT: height_q <= cfg.data[CFG_DIM_W-1:0];
				REG_COS:          cos_q    <= cfg.data[CFG_TRIG_W-1:0];
				REG_SIN:          sin_q    <= cfg.data[CFG_TRIG_W-1:0];
				REG_CENTER_X:     cx_q     <= cfg.data[CFG_CTR_W-1:0];
				REG_CENTER_Y:     cy_q     <= cfg.data[CFG_CTR_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		eff_w = (DW_W'(width_q) > DW_W'(MAX_WIDTH)) ? DW_W'(MAX_WIDTH) : DW_W'(width_q);
		eff_h = (DH_W'(height_q) > DH_W'(MAX_HEIGHT)) ? DH_W'(MAX_HEIGHT) : DH_W'(height_q);
		req_acc    = req.valid && req.ready;
		req_cmd    = cmd_t'(req.command);
		req_inside = (DW_W'(req.pixel_x) < eff_w) && (DH_W'(req.pixel_y) < eff_h);
		req_addr   = {YAW'(req.pixel_y), XAW'(req.pixel_x)};
		loop_addr  = {YAW'(j_q), XAW'(i_q)};
		last_i     = (i_q == eff_w - DW_W'(1));
		last_j     = (j_q == eff_h - DH_W'(1));
		slot_free  = !rsp_valid_q || rsp.ready;
		src_x = signed'(XW'(i_q)) - {{(XW-CFG_CTR_W){cx_q[CFG_CTR_W-1]}}, cx_q};
		src_y = signed'(XW'(j_q)) - {{(XW-CFG_CTR_W){cy_q[CFG_CTR_W-1]}}, cy_q};
		dst_x = {mac_dx[RW-1], mac_dx} + {{(DXW-CFG_CTR_W){cx_q[CFG_CTR_W-1]}}, cx_q};
		dst_y = {mac_dy[RW-1], mac_dy} + {{(DXW-CFG_CTR_W){cy_q[CFG_CTR_W-1]}}, cy_q};
		dst_hit = !dst_x[DXW-1] && !dst_y[DXW-1] &&
			(dst_x < signed'(DXW'(eff_w))) && (dst_y < signed'(DXW'(eff_h)));
		dst_addr = {YAW'(dst_y), XAW'(dst_x)};
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (req_acc) begin
					case (req_cmd)
						CMD_READ:   state_d = S_RD;
						CMD_ROTATE: state_d = (eff_w == '0 || eff_h == '0) ? S_FIN : S_CPY_RD;
						default:    state_d = S_FIN;
					endcase
				end
			end
			S_RD:       state_d = S_FIN;
			S_CPY_RD:   state_d = S_CPY_WR;
			S_CPY_WR:   state_d = (last_i && last_j) ? S_MAP_RD : S_CPY_RD;
			S_MAP_RD:   state_d = S_MAP_WAIT;
			S_MAP_WAIT: state_d = mac_done ? S_MAP_WR : S_MAP_WAIT;
			S_MAP_WR:   state_d = (last_i && last_j) ? S_FIN : S_MAP_RD;
			S_FIN:      state_d = slot_free ? S_IDLE : S_FIN;
			default:    state_d = S_IDLE;
		endcase
	end

	// memory controls
	always_comb begin
		req.ready = (state_q == S_IDLE);
		fr_we     = 1'b0;
		fr_waddr  = loop_addr;
		fr_wdata  = PIX_WHITE;
		fr_re     = 1'b0;
		fr_raddr  = loop_addr;
		sc_we     = 1'b0;
		sc_re     = 1'b0;
		mac_start = 1'b0;
		case (state_q)
			S_IDLE: begin
				fr_waddr = req_addr;
				fr_wdata = {req.red_in, req.green_in, req.blue_in};
				fr_raddr = req_addr;
				fr_we    = req_acc && req_cmd == CMD_WRITE && req_inside;
				fr_re    = req_acc && req_cmd == CMD_READ && req_inside;
			end
			S_CPY_RD: fr_re = 1'b1;
			S_CPY_WR: begin
				fr_we = 1'b1;
				sc_we = 1'b1;
			end
			S_MAP_RD: begin
				sc_re     = 1'b1;
				mac_start = 1'b1;
			end
			S_MAP_WR: begin
				fr_we    = dst_hit;
				fr_waddr = dst_addr;
				fr_wdata = sc_rdata;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			i_q         <= '0;
			j_q         <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_IDLE && req_acc) begin
				i_q <= '0;
				j_q <= '0;
			end else if (state_q == S_CPY_WR || state_q == S_MAP_WR) begin
				if (last_j) begin
					j_q <= '0;
					i_q <= last_i ? '0 : i_q + DW_W'(1);
				end else begin
					j_q <= j_q + DH_W'(1);
				end
			end
			if (state_q == S_FIN && slot_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && req_acc) begin
			inside_q <= req_inside;
			pix_q    <= '0;
			case (req_cmd)
				CMD_WRITE:  status_q <= !req_inside;
				CMD_READ:   status_q <= !req_inside;
				CMD_ROTATE: status_q <= 1'b0;
				default:    status_q <= 1'b1;
			endcase
		end else if (state_q == S_RD && inside_q) begin
			pix_q <= fr_rdata;
		end
		if (state_q == S_FIN && slot_free) begin
			rsp_status_q <= status_q;
			rsp_pix_q    <= pix_q;
		end
	end

	assign rsp.valid     = rsp_valid_q;
	assign rsp.status    = rsp_status_q;
	assign rsp.red_out   = rsp_pix_q[3*COLOR_W-1:2*COLOR_W];
	assign rsp.green_out = rsp_pix_q[2*COLOR_W-1:COLOR_W];
	assign rsp.blue_out  = rsp_pix_q[COLOR_W-1:0];

	irn_mem #(.ADDR_W(MAW), .DATA_W(PIX_W)) u_frame (
		.clk   (clk),
		.we    (fr_we),
		.waddr (fr_waddr),
		.wdata (fr_wdata),
		.re    (fr_re),
		.raddr (fr_raddr),
		.rdata (fr_rdata)
	);

	irn_mem #(.ADDR_W(MAW), .DATA_W(PIX_W)) u_scratch (
		.clk   (clk),
		.we    (sc_we),
		.waddr (loop_addr),
		.wdata (fr_rdata),
		.re    (sc_re),
		.raddr (loop_addr),
		.rdata (sc_rdata)
	);

	irn_mac #(.XW(XW), .TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mac_start),
		.x      (src_x),
		.y      (src_y),
		.cos_v  (cos_q),
		.sin_v  (sin_q),
		.done   (mac_done),
		.dx     (mac_dx),
		.dy     (mac_dy)
	);
endmodule

// ===== rtl/irn_chk.sv =====
// port level checks for the image rotate unit
module irn_chk import irn_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               req_valid,
	input logic               req_ready,
	input logic               rsp_valid,
	input logic               rsp_ready,
	input logic               rsp_status,
	input logic [COLOR_W-1:0] rsp_red,
	input logic [COLOR_W-1:0] rsp_green,
	input logic [COLOR_W-1:0] rsp_blue
);
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("result dropped while stalled");

	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=>
		$stable(rsp_status) && $stable(rsp_red) && $stable(rsp_green) && $stable(rsp_blue))
		else $error("result changed while stalled");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("item taken while previous item still in work");

	a_color_only_on_success: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_red != '0 || rsp_green != '0 || rsp_blue != '0) |-> !rsp_status)
		else $error("colors returned with failing status");
endmodule

bind image_rotate_nearest_forward_unit irn_chk u_irn_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_valid  (req.valid),
	.req_ready  (req.ready),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.rsp_status (rsp.status),
	.rsp_red    (rsp.red_out),
	.rsp_green  (rsp.green_out),
	.rsp_blue   (rsp.blue_out)
);

// ===== dv/irn_tb_if_note.sv =====
`timescale 1ns / 1ps
// small shared testbench constants for the image rotate unit bench
package irn_tb_pkg;
	import irn_pkg::*;

	// code the block does not define; must come back with status 1
	localparam logic [CMD_W-1:0] CMD_UNKNOWN = 2'd3;

	typedef struct packed {
		logic [CMD_W-1:0]       command;
		logic [PIX_COORD_W-1:0] pixel_x;
		logic [PIX_COORD_W-1:0] pixel_y;
		logic [COLOR_W-1:0]     red;
		logic [COLOR_W-1:0]     green;
		logic [COLOR_W-1:0]     blue;
	} pix_cmd_t;

	typedef struct packed {
		logic               status;
		logic [COLOR_W-1:0] red;
		logic [COLOR_W-1:0] green;
		logic [COLOR_W-1:0] blue;
	} pix_rsp_t;
endpackage

// ===== dv/image_rotate_nearest_forward_unit_tb.sv =====
`timescale 1ns / 1ps
// testbench for the image rotate unit: random pixel traffic and rotations against a predictor
module image_rotate_nearest_forward_unit_tb;
	import irn_pkg::*;
	import irn_tb_pkg::*;

	localparam int MW = DEF_MAX_WIDTH;
	localparam int MH = DEF_MAX_HEIGHT;
	localparam int FB = DEF_TRIG_FRAC_BITS;

	logic clk;
	logic arst_n;

	irn_req_if req ();
	irn_rsp_if rsp ();
	irn_cfg_if cfg ();

	image_rotate_nearest_forward_unit uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req.sink),
		.rsp    (rsp.source),
		.cfg    (cfg.sink)
	);

	// predicted frame contents and which entries hold defined data
	logic [PIX_W-1:0] frame_pix [MW*MH];
	bit               frame_known [MW*MH];
	logic [PIX_W-1:0] scratch_pix [MW*MH];
	bit               scratch_known [MW*MH];

	logic [CFG_DIM_W-1:0]         width_reg;
	logic [CFG_DIM_W-1:0]         height_reg;
	logic signed [CFG_TRIG_W-1:0] cos_reg;
	logic signed [CFG_TRIG_W-1:0] sin_reg;
	logic signed [CFG_CTR_W-1:0]  cx_reg;
	logic signed [CFG_CTR_W-1:0]  cy_reg;

	pix_cmd_t pending_cmds [$];
	pix_rsp_t expected_rsps [$];

	int send_idle_pct;
	int recv_stall_pct;
	int mismatches;
	bit hold_start;
	int hold_cnt;

	function automatic int eff_w();
		return (width_reg > MW) ? MW : int'(width_reg);
	endfunction

	function automatic int eff_h();
		return (height_reg > MH) ? MH : int'(height_reg);
	endfunction

	function automatic longint round_q(longint v);
		longint mag;
		longint q;
		mag = (v < 0) ? -v : v;
		q = (mag + (longint'(1) << (FB - 1))) >>> FB;
		return (v < 0) ? -q : q;
	endfunction

	task automatic rotate_frame();
		int w;
		int h;
		int a;
		longint c;
		longint s;
		longint cx;
		longint cy;
		longint x;
		longint y;
		longint dx;
		longint dy;
		w = eff_w();
		h = eff_h();
		c = cos_reg;
		s = sin_reg;
		cx = cx_reg;
		cy = cy_reg;
		for (int i = 0; i < w; i++) begin
			for (int j = 0; j < h; j++) begin
				a = j * MW + i;
				scratch_pix[a] = frame_pix[a];
				scratch_known[a] = frame_known[a];
				frame_pix[a] = PIX_WHITE;
				frame_known[a] = 1;
			end
		end
		for (int i = 0; i < w; i++) begin
			for (int j = 0; j < h; j++) begin
				x = i - cx;
				y = j - cy;
				dx = round_q(x * c + y * s) + cx;
				dy = round_q(y * c - x * s) + cy;
				if (dx >= 0 && dy >= 0 && dx < w && dy < h) begin
					a = int'(dy) * MW + int'(dx);
					frame_pix[a] = scratch_pix[j * MW + i];
					frame_known[a] = scratch_known[j * MW + i];
				end
			end
		end
	endtask

	function automatic bit in_frame(pix_cmd_t it);
		return it.pixel_x < eff_w() && it.pixel_y < eff_h();
	endfunction

	// queue one command and its predicted response
	task automatic push_cmd(pix_cmd_t it);
		pix_rsp_t r;
		int a;
		r = '0;
		a = int'(it.pixel_y) * MW + int'(it.pixel_x);
		case (it.command)
			CMD_WRITE: begin
				if (in_frame(it)) begin
					frame_pix[a] = {it.red, it.green, it.blue};
					frame_known[a] = 1;
				end else begin
					r.status = 1;
				end
			end
			CMD_READ: begin
				if (in_frame(it))
					{r.red, r.green, r.blue} = frame_pix[a];
				else
					r.status = 1;
			end
			CMD_ROTATE: rotate_frame();
			default: r.status = 1;
		endcase
		pending_cmds.push_back(it);
		expected_rsps.push_back(r);
	endtask

	task automatic push_fields(logic [CMD_W-1:0] c, int x, int y, logic [PIX_W-1:0] p);
		pix_cmd_t it;
		it.command = c;
		it.pixel_x = PIX_COORD_W'(x);
		it.pixel_y = PIX_COORD_W'(y);
		{it.red, it.green, it.blue} = p;
		// never read an entry that holds no defined data
		if (c == CMD_READ && in_frame(it) && !frame_known[y * MW + x])
			it.command = CMD_WRITE;
		push_cmd(it);
	endtask

	task automatic random_cmd();
		int k;
		int x;
		int y;
		logic [CMD_W-1:0] c;
		k = $urandom_range(99);
		if (k < 45)
			c = CMD_WRITE;
		else if (k < 88)
			c = CMD_READ;
		else if (k < 92)
			c = CMD_ROTATE;
		else if (k < 95)
			c = CMD_UNKNOWN;
		else
			c = CMD_READ;
		if ($urandom_range(9) == 0) begin
			x = $urandom_range(511);
			y = $urandom_range(511);
		end else begin
			x = $urandom_range(eff_w() + 1);
			y = $urandom_range(eff_h() + 1);
		end
		push_fields(c, x, y, PIX_W'($urandom));
	endtask

	task automatic drain();
		while (pending_cmds.size() != 0 || expected_rsps.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg.valid <= 1;
		cfg.index <= idx;
		cfg.data <= val;
		@(posedge clk);
		while (!cfg.ready)
			@(posedge clk);
		cfg.valid <= 0;
		case (idx)
			REG_FRAME_WIDTH:  width_reg = val[CFG_DIM_W-1:0];
			REG_FRAME_HEIGHT: height_reg = val[CFG_DIM_W-1:0];
			REG_COS:          cos_reg = val;
			REG_SIN:          sin_reg = val;
			REG_CENTER_X:     cx_reg = val[CFG_CTR_W-1:0];
			REG_CENTER_Y:     cy_reg = val[CFG_CTR_W-1:0];
			default: ;
		endcase
	endtask

	task automatic set_frame(int w, int h, int c, int s, int cx, int cy);
		write_reg(REG_FRAME_WIDTH, CFG_DATA_W'(w));
		write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(h));
		write_reg(REG_COS, CFG_DATA_W'(c));
		write_reg(REG_SIN, CFG_DATA_W'(s));
		write_reg(REG_CENTER_X, CFG_DATA_W'(cx));
		write_reg(REG_CENTER_Y, CFG_DATA_W'(cy));
	endtask

	task automatic random_angle_frame();
		int c;
		int s;
		c = int'($urandom_range(32768)) - 16384;
		s = int'($urandom_range(32768)) - 16384;
		set_frame($urandom_range(1, 16), $urandom_range(1, 16), c, s,
			int'($urandom_range(30)) - 8, int'($urandom_range(30)) - 8);
	endtask

	// random traffic with some rotates mixed in; reads of unwritten pixels become writes
	task automatic random_phase(int n);
		for (int i = 0; i < n; i++)
			random_cmd();
	endtask

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("DONE: errors detected");
		$finish;
	end

	// long receiver hold-off, counted here
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_cnt <= 0;
		end else if (hold_start) begin
			hold_cnt <= 300;
		end else if (hold_cnt != 0) begin
			hold_cnt <= hold_cnt - 1;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req.valid <= 0;
			req.command <= CMD_WRITE;
			req.pixel_x <= '0;
			req.pixel_y <= '0;
			req.red_in <= '0;
			req.green_in <= '0;
			req.blue_in <= '0;
		end else if (!req.valid || req.ready) begin
			if (req.valid && req.ready)
				void'(pending_cmds.pop_front());
			if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				req.valid <= 1;
				req.command <= pending_cmds[0].command;
				req.pixel_x <= pending_cmds[0].pixel_x;
				req.pixel_y <= pending_cmds[0].pixel_y;
				req.red_in <= pending_cmds[0].red;
				req.green_in <= pending_cmds[0].green;
				req.blue_in <= pending_cmds[0].blue;
			end else begin
				req.valid <= 0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.ready <= 0;
		end else begin
			rsp.ready <= hold_cnt == 0 && !hold_start && $urandom_range(99) >= recv_stall_pct;
		end
	end

	always @(posedge clk) begin
		pix_rsp_t e;
		if (arst_n && rsp.valid && rsp.ready) begin
			if (expected_rsps.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected response status=%0d rgb=%h %h %h", rsp.status,
						rsp.red_out, rsp.green_out, rsp.blue_out);
			end else begin
				e = expected_rsps.pop_front();
				if (rsp.status !== e.status || rsp.red_out !== e.red ||
				    rsp.green_out !== e.green || rsp.blue_out !== e.blue) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t mismatch: exp status=%0d rgb=%h %h %h, got %0d %h %h %h",
							$realtime, e.status, e.red, e.green, e.blue, rsp.status,
							rsp.red_out, rsp.green_out, rsp.blue_out);
				end
			end
		end
	end

	initial begin
		mismatches = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_start = 0;
		width_reg = 256;
		height_reg = 256;
		cos_reg = 16384;
		sin_reg = 0;
		cx_reg = 0;
		cy_reg = 0;
		cfg.valid = 0;
		cfg.index = '0;
		cfg.data = '0;
		arst_n = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1;
		repeat (2) @(posedge clk);

		// directed: 4x3 frame, extremes, every command, a 90 degree turn
		set_frame(4, 3, 0, 16384, 1, 1);
		for (int y = 0; y < 3; y++)
			for (int x = 0; x < 4; x++)
				push_fields(CMD_WRITE, x, y, (x == 0) ? 24'hFFFFFF : PIX_W'($urandom));
		push_fields(CMD_READ, 3, 2, '0);
		push_fields(CMD_WRITE, 511, 0, 24'h123456);
		push_fields(CMD_READ, 0, 511, '0);
		push_fields(CMD_WRITE, 4, 2, 24'h000000);
		push_fields(CMD_UNKNOWN, 1, 1, 24'hFFFFFF);
		push_fields(CMD_ROTATE, 0, 0, '0);
		for (int x = 0; x < 4; x++)
			push_fields(CMD_READ, x, x % 3, '0);
		drain();

		// zero-size frame: everything out of range
		set_frame(0, 5, 16384, 0, 0, 0);
		push_fields(CMD_WRITE, 0, 0, 24'hABCDEF);
		push_fields(CMD_READ, 0, 0, '0);
		push_fields(CMD_ROTATE, 0, 0, '0);
		drain();

		// oversized width saturates; full-range trig and center extremes
		set_frame(511, 2, -16384, 16384, -512, 511);
		random_phase(20);
		drain();
		set_frame(1, 256, 16384, -16384, 511, -512);
		random_phase(15);
		drain();
		set_frame(256, 1, -16384, 0, 128, 0);
		random_phase(15);
		drain();

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 60; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 60; end
				default: begin send_idle_pct = 30; recv_stall_pct = 30; end
			endcase
			random_angle_frame();
			random_phase(50);
			if (ph == 0) begin
				@(posedge clk);
				hold_start <= 1;
				@(posedge clk);
				hold_start <= 0;
			end
			if (ph == 2)
				drain();
			random_phase(40);
			drain();
		end
		send_idle_pct = 0;
		recv_stall_pct = 0;
		random_angle_frame();
		random_phase(30);
		drain();
		repeat (20) @(posedge clk);
		if (mismatches == 0 && expected_rsps.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/irn_pkg.sv
rtl/irn_if.sv
rtl/irn_mem.sv
rtl/irn_mac.sv
rtl/image_rotate_nearest_forward_unit.sv
rtl/irn_chk.sv
dv/irn_tb_if_note.sv
dv/image_rotate_nearest_forward_unit_tb.sv
